FILE: rtl/core/hds_pkg.sv
// Shared constants and types for the 2D heat diffusion stencil.
package hds_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int SAMPLE_BITS = 32;

   localparam int COL_BITS        = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS      = COL_BITS + 1;
   localparam int GRID_WIDTH_BITS = 11;
   localparam int HEIGHT_BITS     = 16;
   localparam int COEF_BITS       = 16;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 2;

   localparam int FRAC_BITS = 16;
   localparam int ONE_Q16   = 1 << FRAC_BITS;
   localparam int CC_BITS   = COEF_BITS + 3;
   localparam int SUM_BITS  = SAMPLE_BITS + 1;
   localparam int ACC_BITS  = SAMPLE_BITS + 20;
   localparam int RND_BITS  = ACC_BITS - FRAC_BITS;

   localparam logic [GRID_WIDTH_BITS-1:0] GRID_WIDTH_RESET  = GRID_WIDTH_BITS'(64);
   localparam logic [HEIGHT_BITS-1:0]     GRID_HEIGHT_RESET = HEIGHT_BITS'(64);
   localparam logic [COEF_BITS-1:0]       COEF_X_RESET      = COEF_BITS'(8192);
   localparam logic [COEF_BITS-1:0]       COEF_Y_RESET      = COEF_BITS'(8192);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_COEF_X      = 2'd2,
      CSR_COEF_Y      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GRID_WIDTH_BITS-1:0] grid_width;
      logic [HEIGHT_BITS-1:0]     grid_height;
      logic [COEF_BITS-1:0]       coef_x;
      logic [COEF_BITS-1:0]       coef_y;
   } cfg_type;

   typedef struct packed {
      logic [COL_BITS-1:0]    col;
      logic [HEIGHT_BITS-1:0] row;
      logic                   last;
   } meta_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] bottom;
      logic signed [SAMPLE_BITS-1:0] centre;
      logic signed [SAMPLE_BITS-1:0] top;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      meta_type                      meta;
   } window_type;

endpackage

FILE: rtl/core/heat_diffusion_stencil_2d.sv
// Top level of the five-point explicit 2D heat diffusion stencil.
// Takes one grid sample per clock in raster order, halo included, unless
// rsp_ready holds the pipeline back, and returns the updated value of each
// interior cell once its bottom neighbor has arrived; samples of the first
// and last columns and of the first two rows give no response. Sustained
// rate is one request per cycle while rsp_ready stays high, set by the
// single combined line store (upper and middle rows in one word), which is
// written at the current column and read one column ahead for every
// request. A response passes the window register, neighbor sums, products,
// accumulate, then round and saturate before it leaves the output register.
// The line store has no reset pass and is valid once the first two rows of
// a grid have streamed through. Write the grid size and coefficients only
// while no request is in flight.
module heat_diffusion_stencil_2d
   import hds_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_grid_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_new_value,
   output logic [COL_BITS-1:0]           rsp_cell_col,
   output logic [HEIGHT_BITS-1:0]        rsp_cell_row,
   output logic                          rsp_last_cell,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       win_valid, win_ready;
   window_type win;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_WIDTH:  cfg_in.grid_width  = csr_wdata[GRID_WIDTH_BITS-1:0];
            CSR_GRID_HEIGHT: cfg_in.grid_height = csr_wdata[HEIGHT_BITS-1:0];
            CSR_COEF_X:      cfg_in.coef_x      = csr_wdata[COEF_BITS-1:0];
            CSR_COEF_Y:      cfg_in.coef_y      = csr_wdata[COEF_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= GRID_WIDTH_RESET;
         cfg_ff.grid_height <= GRID_HEIGHT_RESET;
         cfg_ff.coef_x      <= COEF_X_RESET;
         cfg_ff.coef_y      <= COEF_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hds_window u_window (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_grid_start (req_grid_start),
      .win_valid      (win_valid),
      .win_ready      (win_ready),
      .win            (win)
   );

   hds_stencil u_stencil (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .win_valid     (win_valid),
      .win_ready     (win_ready),
      .win           (win),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_new_value (rsp_new_value),
      .rsp_cell_col  (rsp_cell_col),
      .rsp_cell_row  (rsp_cell_row),
      .rsp_last_cell (rsp_last_cell)
   );

`ifndef ASSERT_OFF
   // An empty output register means the whole pipeline can advance.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output register");

   // Only interior cells are ever reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cell_col != '0) && (rsp_cell_row != '0))
      else $error("response for a halo cell");

   // Reset flushes every pipeline stage.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

FILE: rtl/core/hds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hds_ram #(
   parameter int DATA_BITS = 64,
   parameter int DEPTH     = 1024
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_BITS-1:0]       wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_BITS-1:0]       rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/hds_window.sv
// Raster position tracking, line store and the five-point window register.
module hds_window
   import hds_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_grid_start,
   output logic                          win_valid,
   input  logic                          win_ready,
   output window_type                    win
);

   logic [COL_BITS-1:0]    col_ff, col_in, col_cur, rd_addr;
   logic [HEIGHT_BITS-1:0] row_ff, row_in, row_cur, h_eff;
   logic [WIDTH_BITS-1:0]  w_eff, col_p1, col_p2;
   logic [HEIGHT_BITS:0]   row_p1;
   logic                   accept, row_end, emit, last;

   logic [2*SAMPLE_BITS-1:0]      rd_data, wr_data;
   logic signed [SAMPLE_BITS-1:0] rd_mid, rd_up;
   logic signed [SAMPLE_BITS-1:0] left_ff, left_in;

   logic       win_valid_ff, win_valid_in;
   window_type win_ff, win_in;

   // Effective grid size after clamping.
   always_comb begin
      if (cfg.grid_width < GRID_WIDTH_BITS'(3)) begin
         w_eff = WIDTH_BITS'(3);
      end else if (32'(cfg.grid_width) > 32'(MAX_WIDTH)) begin
         w_eff = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w_eff = WIDTH_BITS'(cfg.grid_width);
      end
      if (cfg.grid_height < HEIGHT_BITS'(3)) begin
         h_eff = HEIGHT_BITS'(3);
      end else begin
         h_eff = cfg.grid_height;
      end
   end

   assign req_ready = !win_valid_ff || win_ready;
   assign accept    = req_valid && req_ready;

   assign col_cur = req_grid_start ? '0 : col_ff;
   assign row_cur = req_grid_start ? '0 : row_ff;
   assign col_p1  = {1'b0, col_cur} + WIDTH_BITS'(1);
   assign col_p2  = {1'b0, col_cur} + WIDTH_BITS'(2);
   assign row_p1  = {1'b0, row_cur} + (HEIGHT_BITS+1)'(1);
   assign row_end = col_p1 >= w_eff;

   // The read for the next column lands while this sample sits in the
   // window register, giving its right neighbor; it also serves as the
   // centre and top of the next sample.
   assign rd_addr = row_end ? '0 : col_p1[COL_BITS-1:0];
   assign rd_mid  = $signed(rd_data[SAMPLE_BITS-1:0]);
   assign rd_up   = $signed(rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
   assign wr_data = {rd_mid, req_sample};

   assign emit = (row_cur >= HEIGHT_BITS'(2)) && (row_cur < h_eff)
              && (col_cur != '0) && (col_p2 <= w_eff);
   assign last = (col_p2 == w_eff) && (row_p1 == {1'b0, h_eff});

   hds_ram #(
      .DATA_BITS (2*SAMPLE_BITS),
      .DEPTH     (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_cur),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = (row_p1 >= {1'b0, h_eff}) ? '0 : row_p1[HEIGHT_BITS-1:0];
         end else begin
            col_in = col_p1[COL_BITS-1:0];
            row_in = row_cur;
         end
      end
   end

   assign left_in      = rd_mid;
   assign win_valid_in = req_ready ? (accept && emit) : win_valid_ff;

   always_comb begin
      win_in           = win_ff;
      win_in.bottom    = req_sample;
      win_in.centre    = rd_mid;
      win_in.top       = rd_up;
      win_in.left      = left_ff;
      win_in.right     = '0;
      win_in.meta.col  = col_cur;
      win_in.meta.row  = row_cur - HEIGHT_BITS'(1);
      win_in.meta.last = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         win_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         win_valid_ff <= win_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff <= left_in;
         win_ff  <= win_in;
      end
   end

   // Right neighbor comes straight from the line store output, which holds
   // until the next request is taken.
   always_comb begin
      win       = win_ff;
      win.right = rd_mid;
   end

   assign win_valid = win_valid_ff;

endmodule

FILE: rtl/core/hds_stencil.sv
// Stencil arithmetic: neighbor sums, products, accumulate, round and saturate.
module hds_stencil
   import hds_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          win_valid,
   output logic                          win_ready,
   input  window_type                    win,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_new_value,
   output logic [COL_BITS-1:0]           rsp_cell_col,
   output logic [HEIGHT_BITS-1:0]        rsp_cell_row,
   output logic                          rsp_last_cell
);

   localparam int PC_BITS = CC_BITS + SAMPLE_BITS;
   localparam int PS_BITS = COEF_BITS + 1 + SUM_BITS;
   localparam logic signed [RND_BITS-1:0] SAT_HI =
      RND_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [RND_BITS-1:0] SAT_LO = ~SAT_HI;

   logic signed [CC_BITS-1:0] coef_c;
   logic signed [COEF_BITS:0] coef_xs, coef_ys;

   logic ready_a, ready_m, ready_s, ready_o;

   // Stage A: neighbor sums
   logic                          a_valid_ff, a_valid_in;
   logic signed [SUM_BITS-1:0]    a_sum_x_ff, a_sum_x_in, a_sum_y_ff, a_sum_y_in;
   logic signed [SAMPLE_BITS-1:0] a_centre_ff;
   meta_type                      a_meta_ff;

   // Stage M: products
   logic                      m_valid_ff, m_valid_in;
   logic signed [PC_BITS-1:0] m_prod_c_ff, m_prod_c_in;
   logic signed [PS_BITS-1:0] m_prod_x_ff, m_prod_x_in, m_prod_y_ff, m_prod_y_in;
   meta_type                  m_meta_ff;

   // Stage S: accumulate
   logic                       s_valid_ff, s_valid_in;
   logic signed [ACC_BITS-1:0] s_acc_ff, s_acc_in;
   meta_type                   s_meta_ff;

   // Output register
   logic                          o_valid_ff, o_valid_in;
   logic signed [ACC_BITS-1:0]    rounded;
   logic signed [RND_BITS-1:0]    shifted;
   logic signed [SAMPLE_BITS-1:0] o_value_ff, o_value_in;
   meta_type                      o_meta_ff;

   assign coef_c = CC_BITS'(ONE_Q16) - $signed({2'b00, cfg.coef_x, 1'b0})
                 - $signed({2'b00, cfg.coef_y, 1'b0});
   assign coef_xs = $signed({1'b0, cfg.coef_x});
   assign coef_ys = $signed({1'b0, cfg.coef_y});

   assign ready_o   = !o_valid_ff || rsp_ready;
   assign ready_s   = !s_valid_ff || ready_o;
   assign ready_m   = !m_valid_ff || ready_s;
   assign ready_a   = !a_valid_ff || ready_m;
   assign win_ready = ready_a;

   assign a_valid_in = ready_a ? win_valid : a_valid_ff;
   assign a_sum_x_in = SUM_BITS'(win.left) + SUM_BITS'(win.right);
   assign a_sum_y_in = SUM_BITS'(win.top) + SUM_BITS'(win.bottom);

   assign m_valid_in  = ready_m ? a_valid_ff : m_valid_ff;
   assign m_prod_c_in = coef_c * a_centre_ff;
   assign m_prod_x_in = coef_xs * a_sum_x_ff;
   assign m_prod_y_in = coef_ys * a_sum_y_ff;

   assign s_valid_in = ready_s ? m_valid_ff : s_valid_ff;
   assign s_acc_in   = ACC_BITS'(m_prod_c_ff) + ACC_BITS'(m_prod_x_ff)
                     + ACC_BITS'(m_prod_y_ff);

   // Round to nearest, ties up: add half an LSB then floor.
   assign o_valid_in = ready_o ? s_valid_ff : o_valid_ff;
   assign rounded    = s_acc_ff + ACC_BITS'(ONE_Q16 / 2);
   assign shifted    = rounded[ACC_BITS-1:FRAC_BITS];

   always_comb begin
      if (shifted > SAT_HI) begin
         o_value_in = SAT_HI[SAMPLE_BITS-1:0];
      end else if (shifted < SAT_LO) begin
         o_value_in = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         o_value_in = shifted[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         m_valid_ff <= m_valid_in;
         s_valid_ff <= s_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         a_sum_x_ff  <= a_sum_x_in;
         a_sum_y_ff  <= a_sum_y_in;
         a_centre_ff <= win.centre;
         a_meta_ff   <= win.meta;
      end
      if (ready_m) begin
         m_prod_c_ff <= m_prod_c_in;
         m_prod_x_ff <= m_prod_x_in;
         m_prod_y_ff <= m_prod_y_in;
         m_meta_ff   <= a_meta_ff;
      end
      if (ready_s) begin
         s_acc_ff  <= s_acc_in;
         s_meta_ff <= m_meta_ff;
      end
      if (ready_o) begin
         o_value_ff <= o_value_in;
         o_meta_ff  <= s_meta_ff;
      end
   end

   assign rsp_valid     = o_valid_ff;
   assign rsp_new_value = o_value_ff;
   assign rsp_cell_col  = o_meta_ff.col;
   assign rsp_cell_row  = o_meta_ff.row;
   assign rsp_last_cell = o_meta_ff.last;

endmodule
